### rtl/core/p25lf_pkg.sv
// ----------------------------------------------------------------------------
// p25lf_pkg: shared types and microcode for the p25 ldu superframe framer
// holds the opcode set, the control word layout, the microcode rom and the
// record dispatch table used by the sequencer and the datapath
// ----------------------------------------------------------------------------
package p25lf_pkg;

    // widths
    localparam int PC_W     = 6;
    localparam int REP_W    = 4;
    localparam int STEP_W   = 5;
    localparam int ID_W     = 24;
    localparam int CFG_IDX_W = 8;
    localparam int VIDX_W   = 4;

    // superframe
    localparam logic [STEP_W-1:0] LAST_STEP = 5'd17;
    localparam logic [7:0]        CODE_BASE = 8'h62;
    localparam logic [VIDX_W-1:0] IMBE_LAST = 4'd10;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ID      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DESTINATION_ID = 8'd1;

    // opcodes
    localparam logic [2:0] OP_CODE  = 3'd0;  // record code byte
    localparam logic [2:0] OP_LIT   = 3'd1;  // literal byte
    localparam logic [2:0] OP_VOICE = 3'd2;  // held imbe byte
    localparam logic [2:0] OP_DST   = 3'd3;  // destination id byte
    localparam logic [2:0] OP_SRC   = 3'd4;  // source id byte

    // program entry points
    localparam logic [PC_W-1:0] ADDR_TERM  = 6'd0;
    localparam logic [PC_W-1:0] ADDR_HDR   = 6'd2;
    localparam logic [PC_W-1:0] ADDR_R1    = 6'd13;
    localparam logic [PC_W-1:0] ADDR_PLAIN = 6'd17;
    localparam logic [PC_W-1:0] ADDR_TAIL  = 6'd19;
    localparam logic [PC_W-1:0] ADDR_DST   = 6'd21;
    localparam logic [PC_W-1:0] ADDR_SRC   = 6'd24;
    localparam logic [PC_W-1:0] ADDR_R5    = 6'd27;
    localparam logic [PC_W-1:0] ADDR_R6    = 6'd32;
    localparam logic [PC_W-1:0] ADDR_R7    = 6'd37;
    localparam logic [PC_W-1:0] ADDR_R14   = 6'd42;
    localparam logic [PC_W-1:0] ADDR_R15   = 6'd45;
    localparam logic [PC_W-1:0] ADDR_R16   = 6'd50;
    localparam logic [PC_W-1:0] ADDR_R8    = 6'd55;

    typedef struct packed {
        logic [2:0]      op;
        logic [7:0]      lit;
        logic [REP_W-1:0] rep;    // repeat count minus one
        logic            last;    // record ends after this word
        logic            jmp;     // jump to target when the word completes
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic              emit;
        logic [2:0]        op;
        logic [7:0]        lit;
        logic [REP_W-1:0]  rep;
        logic              last;
        logic [STEP_W-1:0] rec_idx;
    } ctl_t;

    function automatic ucode_t uc(input logic [2:0] op, input logic [7:0] lit,
                                  input logic [REP_W-1:0] rep, input logic last,
                                  input logic jmp, input logic [PC_W-1:0] target);
        ucode_t w;
        w.op     = op;
        w.lit    = lit;
        w.rep    = rep;
        w.last   = last;
        w.jmp    = jmp;
        w.target = target;
        return w;
    endfunction

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
        ucode_t w;
        case (addr)
            // terminator: 0x80 then sixteen zeros
            6'd0:  w = uc(OP_LIT,   8'h80, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd1:  w = uc(OP_LIT,   8'h00, 4'd15, 1'b1, 1'b0, ADDR_TERM);
            // header records 0x62 / 0x6b
            6'd2:  w = uc(OP_CODE,  8'h00, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd3:  w = uc(OP_LIT,   8'h02, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd4:  w = uc(OP_LIT,   8'h02, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd5:  w = uc(OP_LIT,   8'h0C, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd6:  w = uc(OP_LIT,   8'h0B, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd7:  w = uc(OP_LIT,   8'h12, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd8:  w = uc(OP_LIT,   8'h64, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd9:  w = uc(OP_LIT,   8'h00, 4'd1,  1'b0, 1'b0, ADDR_TERM);
            6'd10: w = uc(OP_LIT,   8'h80, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd11: w = uc(OP_VOICE, 8'h00, 4'd10, 1'b0, 1'b0, ADDR_TERM);
            6'd12: w = uc(OP_LIT,   8'h00, 4'd0,  1'b1, 1'b0, ADDR_TERM);
            // records 0x63 / 0x6c
            6'd13: w = uc(OP_CODE,  8'h00, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd14: w = uc(OP_VOICE, 8'h00, 4'd10, 1'b0, 1'b0, ADDR_TERM);
            6'd15: w = uc(OP_LIT,   8'h00, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd16: w = uc(OP_LIT,   8'h02, 4'd0,  1'b1, 1'b0, ADDR_TERM);
            // plain 17-byte records, shared voice tail at 19
            6'd17: w = uc(OP_CODE,  8'h00, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd18: w = uc(OP_LIT,   8'h00, 4'd3,  1'b0, 1'b0, ADDR_TERM);
            6'd19: w = uc(OP_VOICE, 8'h00, 4'd10, 1'b0, 1'b0, ADDR_TERM);
            6'd20: w = uc(OP_LIT,   8'h02, 4'd0,  1'b1, 1'b0, ADDR_TERM);
            // record 0x65, destination id
            6'd21: w = uc(OP_CODE,  8'h00, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd22: w = uc(OP_DST,   8'h00, 4'd2,  1'b0, 1'b0, ADDR_TERM);
            6'd23: w = uc(OP_LIT,   8'h00, 4'd0,  1'b0, 1'b1, ADDR_TAIL);
            // record 0x66, source id
            6'd24: w = uc(OP_CODE,  8'h00, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd25: w = uc(OP_SRC,   8'h00, 4'd2,  1'b0, 1'b0, ADDR_TERM);
            6'd26: w = uc(OP_LIT,   8'h00, 4'd0,  1'b0, 1'b1, ADDR_TAIL);
            // record 0x67
            6'd27: w = uc(OP_CODE,  8'h00, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd28: w = uc(OP_LIT,   8'hF0, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd29: w = uc(OP_LIT,   8'h9D, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd30: w = uc(OP_LIT,   8'h6A, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd31: w = uc(OP_LIT,   8'h00, 4'd0,  1'b0, 1'b1, ADDR_TAIL);
            // record 0x68
            6'd32: w = uc(OP_CODE,  8'h00, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd33: w = uc(OP_LIT,   8'h19, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd34: w = uc(OP_LIT,   8'hD4, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd35: w = uc(OP_LIT,   8'h26, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd36: w = uc(OP_LIT,   8'h00, 4'd0,  1'b0, 1'b1, ADDR_TAIL);
            // record 0x69
            6'd37: w = uc(OP_CODE,  8'h00, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd38: w = uc(OP_LIT,   8'hE0, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd39: w = uc(OP_LIT,   8'hEB, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd40: w = uc(OP_LIT,   8'h7B, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd41: w = uc(OP_LIT,   8'h00, 4'd0,  1'b0, 1'b1, ADDR_TAIL);
            // record 0x70
            6'd42: w = uc(OP_CODE,  8'h00, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd43: w = uc(OP_LIT,   8'h80, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd44: w = uc(OP_LIT,   8'h00, 4'd2,  1'b0, 1'b1, ADDR_TAIL);
            // record 0x71
            6'd45: w = uc(OP_CODE,  8'h00, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd46: w = uc(OP_LIT,   8'hAC, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd47: w = uc(OP_LIT,   8'hB8, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd48: w = uc(OP_LIT,   8'hA4, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd49: w = uc(OP_LIT,   8'h00, 4'd0,  1'b0, 1'b1, ADDR_TAIL);
            // record 0x72
            6'd50: w = uc(OP_CODE,  8'h00, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd51: w = uc(OP_LIT,   8'h9B, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd52: w = uc(OP_LIT,   8'hDC, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd53: w = uc(OP_LIT,   8'h75, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd54: w = uc(OP_LIT,   8'h00, 4'd0,  1'b0, 1'b1, ADDR_TAIL);
            // records 0x6a / 0x73
            6'd55: w = uc(OP_CODE,  8'h00, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd56: w = uc(OP_LIT,   8'h00, 4'd1,  1'b0, 1'b0, ADDR_TERM);
            6'd57: w = uc(OP_LIT,   8'h02, 4'd0,  1'b0, 1'b0, ADDR_TERM);
            6'd58: w = uc(OP_VOICE, 8'h00, 4'd10, 1'b0, 1'b0, ADDR_TERM);
            6'd59: w = uc(OP_LIT,   8'h00, 4'd0,  1'b1, 1'b0, ADDR_TERM);
            default: w = uc(OP_LIT, 8'h00, 4'd0,  1'b1, 1'b0, ADDR_TERM);
        endcase
        return w;
    endfunction

    function automatic logic [PC_W-1:0] dispatch(input logic [STEP_W-1:0] step);
        logic [PC_W-1:0] a;
        case (step)
            5'd0, 5'd9:                a = ADDR_HDR;
            5'd1, 5'd10:               a = ADDR_R1;
            5'd2, 5'd11, 5'd12, 5'd13: a = ADDR_PLAIN;
            5'd3:                      a = ADDR_DST;
            5'd4:                      a = ADDR_SRC;
            5'd5:                      a = ADDR_R5;
            5'd6:                      a = ADDR_R6;
            5'd7:                      a = ADDR_R7;
            5'd14:                     a = ADDR_R14;
            5'd15:                     a = ADDR_R15;
            5'd16:                     a = ADDR_R16;
            5'd8, 5'd17:               a = ADDR_R8;
            default:                   a = ADDR_HDR;
        endcase
        return a;
    endfunction

endpackage

### rtl/core/p25_ldu_superframe_framer.sv
// ----------------------------------------------------------------------------
// p25_ldu_superframe_framer: p25 ldu network voice record framer
// turns one imbe voice frame per request into one network record byte stream
// ----------------------------------------------------------------------------
// usage
// - input channel (in_valid / in_stall): one request per record. req_type 0
//   sends the imbe frame in imbe_head / imbe_tail, req_type 1 ends the call
// - output channel (out_valid / out_stall): one byte per transfer, last_byte
//   flags the final byte, record_index gives the superframe position
// - config channel (cfg_valid / cfg_ready): index 0 source id, index 1
//   destination id; cfg_ready is always high, write only while idle
// - an 18-position superframe counter picks the record template (codes
//   0x62..0x73, 14 to 22 bytes); a stop request sends the 17-byte 0x80
//   terminator and returns the counter to position 0
// - a taken request loads the program counter; each byte then passes through the output register
// - throughput: one byte per cycle out of the microcode sequencer while the
//   output register is not held by out_stall; a new request waits for the record end
// - in_stall stays high from the cycle after a request until the sequencer
//   has handed over the last byte of its record
// - while out_stall is high the byte in the output register holds and the
//   sequencer waits on that step
// - reset clears the counter, the ids and the output valid; the imbe store
//   is loaded by the first voice request
// ----------------------------------------------------------------------------
module p25_ldu_superframe_framer (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                req_type,
    input  logic [23:0]                         imbe_head,
    input  logic [63:0]                         imbe_tail,
    // byte channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          out_byte,
    output logic                                last_byte,
    output logic [p25lf_pkg::STEP_W-1:0]        record_index,
    // config write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [p25lf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [p25lf_pkg::ID_W-1:0]          cfg_data
);

    logic             busy;
    logic             in_accept;
    logic             out_ready;
    p25lf_pkg::ctl_t  ctl;

    // one record at a time: new requests wait while the sequencer runs
    assign in_stall  = busy;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // program counter, repeat counter and superframe position
    p25lf_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_accept),
        .req_type  (req_type),
        .out_ready (out_ready),
        .busy      (busy),
        .ctl       (ctl)
    );

    // imbe store, ids, byte select and output register
    p25lf_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .voice_load   (in_accept && !req_type),
        .imbe_head    (imbe_head),
        .imbe_tail    (imbe_tail),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_stall    (out_stall),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .out_byte     (out_byte),
        .last_byte    (last_byte),
        .record_index (record_index)
    );

endmodule

### rtl/core/p25lf_sequencer.sv
// ----------------------------------------------------------------------------
// p25lf_sequencer: microcode sequencer
// step counter, repeat counter and superframe position; one control word
// per emitted byte goes to the datapath
// ----------------------------------------------------------------------------
module p25lf_sequencer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   req_type,
    input  logic                   out_ready,
    output logic                   busy,
    output p25lf_pkg::ctl_t        ctl
);

    logic                          busy_reg, busy_next;
    logic [p25lf_pkg::PC_W-1:0]    pc_reg, pc_next;
    logic [p25lf_pkg::REP_W-1:0]   rep_reg, rep_next;
    logic [p25lf_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [p25lf_pkg::STEP_W-1:0]  rec_idx_reg, rec_idx_next;

    p25lf_pkg::ucode_t             cw;
    p25lf_pkg::ucode_t             load_cw;
    logic [p25lf_pkg::PC_W-1:0]    load_addr;
    logic                          emit;

    assign cw   = p25lf_pkg::ucode_rom(pc_reg);
    assign emit = busy_reg && out_ready;
    assign busy = busy_reg;

    // address of the next word to enter
    always_comb
    begin
        if (start)
        begin
            load_addr = req_type ? p25lf_pkg::ADDR_TERM : p25lf_pkg::dispatch(step_reg);
        end
        else if (cw.jmp)
        begin
            load_addr = cw.target;
        end
        else
        begin
            load_addr = pc_reg + 6'd1;
        end
    end

    assign load_cw = p25lf_pkg::ucode_rom(load_addr);

    always_comb
    begin
        busy_next    = busy_reg;
        pc_next      = pc_reg;
        rep_next     = rep_reg;
        step_next    = step_reg;
        rec_idx_next = rec_idx_reg;
        if (start)
        begin
            busy_next = 1'b1;
            pc_next   = load_addr;
            rep_next  = load_cw.rep;
            if (req_type)
            begin
                step_next    = '0;
                rec_idx_next = '0;
            end
            else
            begin
                rec_idx_next = step_reg;
                step_next    = (step_reg == p25lf_pkg::LAST_STEP) ? '0 : step_reg + 5'd1;
            end
        end
        else if (emit)
        begin
            if (rep_reg != '0)
            begin
                rep_next = rep_reg - 4'd1;
            end
            else if (cw.last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pc_next  = load_addr;
                rep_next = load_cw.rep;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            pc_reg      <= '0;
            rep_reg     <= '0;
            step_reg    <= '0;
            rec_idx_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            pc_reg      <= pc_next;
            rep_reg     <= rep_next;
            step_reg    <= step_next;
            rec_idx_reg <= rec_idx_next;
        end
    end

    always_comb
    begin
        ctl.emit    = emit;
        ctl.op      = cw.op;
        ctl.lit     = cw.lit;
        ctl.rep     = rep_reg;
        ctl.last    = cw.last && (rep_reg == '0);
        ctl.rec_idx = rec_idx_reg;
    end

endmodule

### rtl/core/p25lf_datapath.sv
// ----------------------------------------------------------------------------
// p25lf_datapath: byte datapath and output register
// holds the imbe frame and the two ids, picks the byte the control word
// asks for and presents it on the output channel
// ----------------------------------------------------------------------------
module p25lf_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  p25lf_pkg::ctl_t                     ctl,
    input  logic                                voice_load,
    input  logic [23:0]                         imbe_head,
    input  logic [63:0]                         imbe_tail,
    input  logic                                cfg_we,
    input  logic [p25lf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [p25lf_pkg::ID_W-1:0]          cfg_data,
    input  logic                                out_stall,
    output logic                                out_ready,
    output logic                                out_valid,
    output logic [7:0]                          out_byte,
    output logic                                last_byte,
    output logic [p25lf_pkg::STEP_W-1:0]        record_index
);

    logic [7:0]                       voice_hold_reg [11];
    logic [p25lf_pkg::ID_W-1:0]       src_id_reg;
    logic [p25lf_pkg::ID_W-1:0]       dst_id_reg;
    logic                             out_valid_reg;
    logic [7:0]                       out_byte_reg;
    logic                             last_reg;
    logic [p25lf_pkg::STEP_W-1:0]     rec_idx_reg;

    logic [p25lf_pkg::VIDX_W-1:0]     vidx;
    logic [7:0]                       byte_sel;

    assign vidx      = p25lf_pkg::IMBE_LAST - ctl.rep;
    assign out_ready = !out_valid_reg || !out_stall;

    function automatic logic [7:0] id_byte(input logic [p25lf_pkg::ID_W-1:0] id,
                                           input logic [1:0] sel);
        logic [7:0] b;
        case (sel)
            2'd2:    b = id[23:16];
            2'd1:    b = id[15:8];
            default: b = id[7:0];
        endcase
        return b;
    endfunction

    always_comb
    begin
        case (ctl.op)
            p25lf_pkg::OP_CODE:  byte_sel = p25lf_pkg::CODE_BASE + {3'b000, ctl.rec_idx};
            p25lf_pkg::OP_LIT:   byte_sel = ctl.lit;
            p25lf_pkg::OP_VOICE: byte_sel = voice_hold_reg[vidx];
            p25lf_pkg::OP_DST:   byte_sel = id_byte(dst_id_reg, ctl.rep[1:0]);
            p25lf_pkg::OP_SRC:   byte_sel = id_byte(src_id_reg, ctl.rep[1:0]);
            default:             byte_sel = ctl.lit;
        endcase
    end

    // imbe frame, byte 0 first
    always_ff @(posedge clk)
    begin
        if (voice_load)
        begin
            voice_hold_reg[0]  <= imbe_head[23:16];
            voice_hold_reg[1]  <= imbe_head[15:8];
            voice_hold_reg[2]  <= imbe_head[7:0];
            voice_hold_reg[3]  <= imbe_tail[63:56];
            voice_hold_reg[4]  <= imbe_tail[55:48];
            voice_hold_reg[5]  <= imbe_tail[47:40];
            voice_hold_reg[6]  <= imbe_tail[39:32];
            voice_hold_reg[7]  <= imbe_tail[31:24];
            voice_hold_reg[8]  <= imbe_tail[23:16];
            voice_hold_reg[9]  <= imbe_tail[15:8];
            voice_hold_reg[10] <= imbe_tail[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_id_reg <= '0;
            dst_id_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == p25lf_pkg::REG_SOURCE_ID)
            begin
                src_id_reg <= cfg_data;
            end
            else if (cfg_index == p25lf_pkg::REG_DESTINATION_ID)
            begin
                dst_id_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            out_byte_reg <= byte_sel;
            last_reg     <= ctl.last;
            rec_idx_reg  <= ctl.rec_idx;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign last_byte    = last_reg;
    assign record_index = rec_idx_reg;

endmodule

### rtl/core/p25lf_checker.sv
// ----------------------------------------------------------------------------
// p25lf_checker: port level checks for the framer
// watches the request and byte channels over time
// ----------------------------------------------------------------------------
module p25lf_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [7:0]                          out_byte,
    input  logic                                last_byte,
    input  logic [p25lf_pkg::STEP_W-1:0]        record_index
);

    // a taken request blocks the next one
    a_req_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken without blocking the next one");

    // a record in flight keeps the request side blocked
    a_mid_record_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_byte |-> in_stall)
        else $error("input open while a record is still being sent");

    // superframe position stays in range
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> record_index <= p25lf_pkg::LAST_STEP)
        else $error("record index out of range");

    // stalled byte holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(last_byte) && $stable(record_index))
        else $error("stalled output byte changed");

endmodule

bind p25_ldu_superframe_framer p25lf_checker u_p25lf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .last_byte    (last_byte),
    .record_index (record_index)
);
